// ===== sv/hmbs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package for the heightmap bilinear sampler.
// Holds the item structs, register indexes and fixed widths; no dependencies.
package hmbs_pkg;

	localparam int unsigned MAX_RESOLUTION = 63;
	localparam int unsigned COORD_WIDTH = 32;
	localparam int unsigned GRID_DEPTH = 4096;
	localparam int unsigned ADDR_W = 12;
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned RES_W = 6;
	localparam int unsigned QUO_W = RES_W + FRAC_W;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef enum logic [2:0] {
		REG_ENABLED = 3'd0,
		REG_GRID_RESOLUTION = 3'd1,
		REG_EXTENT_X = 3'd2,
		REG_EXTENT_Z = 3'd3,
		REG_ORIGIN_X = 3'd4,
		REG_ORIGIN_Y = 3'd5,
		REG_ORIGIN_Z = 3'd6,
		REG_SCALE_Y = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic command;
		logic [11:0] height_index;
		logic signed [31:0] height_value;
		logic signed [31:0] query_x;
		logic signed [31:0] query_y;
		logic signed [31:0] query_z;
	} in_item_t;

	typedef struct packed {
		logic hit;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} out_item_t;

endpackage
`default_nettype wire

// ===== sv/heightmap_bilinear_sampler_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Top level of the heightmap bilinear sampler: sequencer, shared divider,
// shared multiplier and height memory. Depends on hmbs_pkg.
//
// An input item either writes one height entry or samples a world position.
// A write item gives no result. A sample item gives exactly one result
// item: hit, the echoed x and z, and the surface height or the query y on
// a miss.
// A sample result is registered straight from the accepted item when
// sampling is disabled or the resolution is zero, after the x mapping when
// x is off the terrain, after the x division and the z mapping when z is
// off, and on a hit after two 22-step restoring divisions on one shared
// divide unit, four reads of the single-port height memory, and four
// products on one shared multiplier. in_stall stays high until the result
// item is taken. While out_stall is high and a result is pending, the
// result register holds its value and no new input item is taken.
// Reset clears the state and configuration registers to their defaults
// and drops out_valid. The height memory is not cleared: an entry must be
// written before it is read. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must write it only while the block is
// idle, as the block itself does not enforce it.
module heightmap_bilinear_sampler_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire hmbs_pkg::in_item_t in_item,
	output logic out_valid,
	input wire logic out_stall,
	output hmbs_pkg::out_item_t out_item,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MAP, ST_DIV, ST_RD00, ST_RD10, ST_RD01, ST_RD11, ST_RDLAST,
		ST_MUL_A, ST_MUL_B, ST_MUL_C, ST_MUL_D, ST_MUL_E, ST_MUL_F, ST_FIN
	} state_t;

	state_t state_q;
	logic enabled_q;
	logic [5:0] res_q;
	logic [30:0] ext_x_q, ext_z_q, scale_q;
	logic signed [31:0] org_x_q, org_y_q, org_z_q;

	logic signed [31:0] qx_q, qy_q, qz_q;
	logic axis_q;
	logic [31:0] rem_q;
	logic [21:0] dvd_q, quo_q;
	logic [4:0] cnt_q;
	logic [31:0] den_q;
	logic [5:0] x0_q, z0_q;
	logic [15:0] tx_q, tz_q;
	logic signed [31:0] h00_q, h10_q, h01_q, h11_q, hx0_q, hx1_q, h_q;
	logic signed [65:0] prod_q;
	logic out_valid_q;
	hmbs_pkg::out_item_t out_item_q;

	logic signed [31:0] mem_q [hmbs_pkg::GRID_DEPTH];
	logic signed [31:0] rd_data_q;
	logic [11:0] rd_addr;

	logic signed [31:0] map_q, map_org;
	logic [30:0] map_ext;
	logic [31:0] ext_eff, den_c;
	logic signed [33:0] diff_c;
	logic signed [34:0] num_c;
	logic map_ok;
	logic [37:0] p_c;
	logic [32:0] shifted, trial;
	logic bit_in;
	logic [21:0] quo_next;
	logic [5:0] x1, z1;
	logic [6:0] res_p1;
	logic [11:0] a00, a10, a01, a11;
	logic signed [33:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [32:0] sh33;
	logic signed [32:0] hsum_base, hsum;
	logic signed [47:0] y48;
	logic signed [31:0] y_sat;
	logic accept;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	always_comb begin
		map_q = axis_q ? qz_q : qx_q;
		map_org = axis_q ? org_z_q : org_x_q;
		map_ext = axis_q ? ext_z_q : ext_x_q;
		ext_eff = (map_ext == 31'd0) ? 32'd1 : {1'b0, map_ext};
		den_c = {ext_eff[30:0], 1'b0};
		diff_c = 34'(map_q) - 34'(map_org);
		num_c = 35'({diff_c, 1'b0}) + 35'($signed({3'b0, ext_eff}));
		map_ok = !num_c[34] && (num_c[33:0] <= {2'b0, den_c});
		p_c = 38'(num_c[31:0]) * 38'(res_q);
		shifted = {rem_q, dvd_q[21]};
		trial = shifted - {1'b0, den_q};
		bit_in = !trial[32];
		quo_next = {quo_q[20:0], bit_in};
	end

	always_comb begin
		res_p1 = 7'(res_q) + 7'd1;
		x1 = (x0_q == res_q) ? res_q : x0_q + 6'd1;
		z1 = (z0_q == res_q) ? res_q : z0_q + 6'd1;
		a00 = 12'(12'(z0_q) * 12'(res_p1) + 12'(x0_q));
		a10 = 12'(12'(z0_q) * 12'(res_p1) + 12'(x1));
		a01 = 12'(12'(z1) * 12'(res_p1) + 12'(x0_q));
		a11 = 12'(12'(z1) * 12'(res_p1) + 12'(x1));
		case (state_q)
			ST_RD10: rd_addr = a10;
			ST_RD01: rd_addr = a01;
			ST_RD11: rd_addr = a11;
			default: rd_addr = a00;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_MUL_A: begin
				mul_a = 34'(h10_q) - 34'(h00_q);
				mul_b = $signed({16'd0, tx_q});
			end
			ST_MUL_B: begin
				mul_a = 34'(h11_q) - 34'(h01_q);
				mul_b = $signed({16'd0, tx_q});
			end
			ST_MUL_D: begin
				mul_a = 34'(hx1_q) - 34'(hx0_q);
				mul_b = $signed({16'd0, tz_q});
			end
			default: begin
				mul_a = 34'(h_q);
				mul_b = $signed({1'b0, scale_q});
			end
		endcase
		sh33 = prod_q[48:16];
		case (state_q)
			ST_MUL_C: hsum_base = 33'(h01_q);
			default: hsum_base = 33'(h00_q);
		endcase
		hsum = hsum_base + sh33;
		y48 = 48'(org_y_q) + 48'($signed(prod_q[62:16]));
		if (y48 > 48'sh7FFF_FFFF) begin
			y_sat = 32'sh7FFF_FFFF;
		end else if (y48 < -48'sh8000_0000) begin
			y_sat = -32'sh8000_0000;
		end else begin
			y_sat = y48[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_item.command == hmbs_pkg::CMD_WRITE) begin
			mem_q[in_item.height_index] <= in_item.height_value;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			enabled_q <= 1'b0;
			res_q <= 6'd1;
			ext_x_q <= 31'd65536;
			ext_z_q <= 31'd65536;
			org_x_q <= '0;
			org_y_q <= '0;
			org_z_q <= '0;
			scale_q <= 31'd65536;
			axis_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			prod_q <= mul_a * mul_b;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (hmbs_pkg::reg_index_t'(cfg_index))
					hmbs_pkg::REG_ENABLED: enabled_q <= cfg_data[0];
					hmbs_pkg::REG_GRID_RESOLUTION: res_q <= cfg_data[5:0];
					hmbs_pkg::REG_EXTENT_X: ext_x_q <= cfg_data[30:0];
					hmbs_pkg::REG_EXTENT_Z: ext_z_q <= cfg_data[30:0];
					hmbs_pkg::REG_ORIGIN_X: org_x_q <= cfg_data;
					hmbs_pkg::REG_ORIGIN_Y: org_y_q <= cfg_data;
					hmbs_pkg::REG_ORIGIN_Z: org_z_q <= cfg_data;
					hmbs_pkg::REG_SCALE_Y: scale_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && in_item.command == hmbs_pkg::CMD_SAMPLE) begin
						qx_q <= in_item.query_x;
						qy_q <= in_item.query_y;
						qz_q <= in_item.query_z;
						axis_q <= 1'b0;
						if (!enabled_q || res_q == 6'd0) begin
							out_item_q <= '{1'b0, in_item.query_x, in_item.query_y,
								in_item.query_z};
							out_valid_q <= 1'b1;
						end else begin
							state_q <= ST_MAP;
						end
					end
				end
				ST_MAP: begin
					if (!map_ok) begin
						out_item_q <= '{1'b0, qx_q, qy_q, qz_q};
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						rem_q <= p_c[37:6];
						dvd_q <= {p_c[5:0], 16'd0};
						den_q <= den_c;
						quo_q <= '0;
						cnt_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= bit_in ? trial[31:0] : shifted[31:0];
					dvd_q <= {dvd_q[20:0], 1'b0};
					quo_q <= quo_next;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(hmbs_pkg::QUO_W - 1)) begin
						if (axis_q) begin
							z0_q <= quo_next[21:16];
							tz_q <= quo_next[15:0];
							state_q <= ST_RD00;
						end else begin
							x0_q <= quo_next[21:16];
							tx_q <= quo_next[15:0];
							axis_q <= 1'b1;
							state_q <= ST_MAP;
						end
					end
				end
				ST_RD00: state_q <= ST_RD10;
				ST_RD10: begin
					h00_q <= rd_data_q;
					state_q <= ST_RD01;
				end
				ST_RD01: begin
					h10_q <= rd_data_q;
					state_q <= ST_RD11;
				end
				ST_RD11: begin
					h01_q <= rd_data_q;
					state_q <= ST_RDLAST;
				end
				ST_RDLAST: begin
					h11_q <= rd_data_q;
					state_q <= ST_MUL_A;
				end
				ST_MUL_A: state_q <= ST_MUL_B;
				ST_MUL_B: begin
					hx0_q <= hsum[31:0];
					state_q <= ST_MUL_C;
				end
				ST_MUL_C: begin
					hx1_q <= hsum[31:0];
					state_q <= ST_MUL_D;
				end
				ST_MUL_D: state_q <= ST_MUL_E;
				ST_MUL_E: begin
					h_q <= 32'(33'(hx0_q) + sh33);
					state_q <= ST_MUL_F;
				end
				ST_MUL_F: state_q <= ST_FIN;
				ST_FIN: begin
					out_item_q <= '{1'b1, qx_q, y_sat, qz_q};
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken while busy");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q < 5'(hmbs_pkg::QUO_W)))
		else $error("divide step count overrun");

	a_hit_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_item_q.hit) |-> enabled_q)
		else $error("hit reported while disabled");

	a_hit_source: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid_q) && out_item_q.hit) |-> $past(state_q == ST_FIN))
		else $error("hit result not from final step");

endmodule
`default_nettype wire
